// ===== rtl/fwpe_pkg.sv =====
// Package for the priority-extract FIFO: word types, command and status codes,
// the cell operation code and the per-cell data types.
// No dependencies.
package fwpe_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_EXTRACT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] entry_handle;
        logic [7:0]  entry_priority;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_handle;
        logic [7:0]  out_priority;
        logic [4:0]  entry_count;
    } out_word_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  prio;
    } slot_t;

    typedef struct packed {
        logic        found;
        logic [15:0] handle;
        logic [7:0]  prio;
    } tok_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT,
        OP_SCAN
    } cell_op_t;

endpackage

// ===== rtl/fwpe_cell.sv =====
// One storage cell of the queue chain: holds one entry, closes up from its right
// neighbor, and passes the running max-priority token to the right.
// Depends on fwpe_pkg.
module fwpe_cell #(
    parameter int DEPTH = fwpe_pkg::DEPTH_DEF,
    parameter int POS = 0,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  fwpe_pkg::cell_op_t op,
    input  logic [CW-1:0]      sel,
    input  logic [CW-1:0]      cnt,
    input  fwpe_pkg::slot_t    ld,
    input  fwpe_pkg::slot_t    nxt,
    input  fwpe_pkg::tok_t     tok_in,
    input  logic [CW-1:0]      tok_in_idx,
    output fwpe_pkg::slot_t    slot,
    output fwpe_pkg::tok_t     tok,
    output logic [CW-1:0]      tok_idx
);
    import fwpe_pkg::*;

    localparam logic [CW-1:0] POS_C = CW'(POS);

    slot_t         slot_reg, slot_next;
    tok_t          tok_reg, tok_next;
    logic [CW-1:0] tidx_reg, tidx_next;
    logic          take;

    // oldest wins ties: a later cell takes the token only on strictly greater
    assign take = (POS_C < cnt) && (!tok_in.found || (slot_reg.prio > tok_in.prio));

    always_comb
    begin
        slot_next = slot_reg;
        tok_next  = tok_reg;
        tidx_next = tidx_reg;
        case (op)
            OP_LOAD:
            begin
                if (sel == POS_C)
                begin
                    slot_next = ld;
                end
            end
            OP_SHIFT:
            begin
                if (POS_C >= sel)
                begin
                    slot_next = nxt;
                end
            end
            OP_SCAN:
            begin
                if (take)
                begin
                    tok_next.found  = 1'b1;
                    tok_next.handle = slot_reg.handle;
                    tok_next.prio   = slot_reg.prio;
                    tidx_next       = POS_C;
                end
                else
                begin
                    tok_next  = tok_in;
                    tidx_next = tok_in_idx;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        tok_reg  <= tok_next;
        tidx_reg <= tidx_next;
    end

    assign slot    = slot_reg;
    assign tok     = tok_reg;
    assign tok_idx = tidx_reg;

endmodule

// ===== rtl/fifo_with_priority_extract_core.sv =====
// Bounded FIFO of (handle, priority) words with pop-oldest and extract-highest-priority.
// Push, pop and no-op go from idle straight to S_OUT; extract first runs S_SCAN, with the
// max-priority token walking the cell chain one cell per cycle, then S_REMOVE and S_OUT.
// One command is in flight at a time; the output register lets a result wait while
// the next word is accepted. Depends on fwpe_pkg and fwpe_cell.
module fifo_with_priority_extract_core #(
    parameter int DEPTH = fwpe_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwpe_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fwpe_pkg::out_word_t out_data
);
    import fwpe_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_REMOVE = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] scan_reg, scan_next;
    out_word_t     res_reg, res_next;
    out_word_t     out_data_reg, out_data_next;
    logic          out_valid_reg, out_valid_next;

    cell_op_t      op;
    logic [CW-1:0] sel;
    slot_t         ld;
    logic          acc, full, empty;

    slot_t         slot_q [DEPTH];
    tok_t          tok_q  [DEPTH];
    logic [CW-1:0] tidx_q [DEPTH];

    assign ld.handle = in_data.entry_handle;
    assign ld.prio   = in_data.entry_priority;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        slot_t         nxt;
        tok_t          tin;
        logic [CW-1:0] tin_idx;

        if (g == DEPTH - 1)
        begin : g_last
            assign nxt = slot_q[g];
        end
        else
        begin : g_mid
            assign nxt = slot_q[g+1];
        end

        if (g == 0)
        begin : g_first
            assign tin     = '0;
            assign tin_idx = '0;
        end
        else
        begin : g_rest
            assign tin     = tok_q[g-1];
            assign tin_idx = tidx_q[g-1];
        end

        fwpe_cell #(
            .DEPTH (DEPTH),
            .POS   (g)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .sel        (sel),
            .cnt        (count_reg),
            .ld         (ld),
            .nxt        (nxt),
            .tok_in     (tin),
            .tok_in_idx (tin_idx),
            .slot       (slot_q[g]),
            .tok        (tok_q[g]),
            .tok_idx    (tidx_q[g])
        );
    end

    assign in_ready = (state_reg == S_IDLE);
    assign acc      = in_valid && in_ready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        op             = OP_HOLD;
        sel            = count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                    unique case (in_data.command)
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                op         = OP_LOAD;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                op                    = OP_SHIFT;
                                sel                   = '0;
                                res_next.out_handle   = slot_q[0].handle;
                                res_next.out_priority = slot_q[0].prio;
                                count_next            = count_reg - 1'b1;
                            end
                        end
                        CMD_EXTRACT:
                        begin
                            if (empty)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                scan_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.entry_count = 5'(count_next);
                end
            end
            S_SCAN:
            begin
                op        = OP_SCAN;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SW'(DEPTH - 1))
                begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                op                    = OP_SHIFT;
                sel                   = tidx_q[DEPTH-1];
                count_next            = count_reg - 1'b1;
                res_next.status       = ST_OK;
                res_next.out_handle   = tok_q[DEPTH-1].handle;
                res_next.out_priority = tok_q[DEPTH-1].prio;
                res_next.entry_count  = 5'(count_next);
                state_next            = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
